>>> rtl/lcns_pkg.sv
// Shared types and constants for the LWE inverse-CDF noise sampler.
package lcns_pkg;

    // Sampler mode codes
    localparam logic [1:0] MODE_8BIT  = 2'd0;
    localparam logic [1:0] MODE_12BIT = 2'd1;
    localparam logic [1:0] MODE_16BIT = 2'd2;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_TABLE_LEN = 3'd1;
    localparam logic [2:0] REG_ENTRY_0   = 3'd2;

    // Number of CDF entry registers
    localparam int ENTRY_REGS = 5;

    // Field widths
    localparam int RAND_W   = 24;
    localparam int ENTRY_W  = 15;
    localparam int SAMPLE_W = 16;

    // Input word
    typedef struct packed {
        logic [RAND_W-1:0] random_word;
        logic              odd_tail;
    } in_word_t;

    // Output word
    typedef struct packed {
        logic [SAMPLE_W-1:0] noise_sample;
        logic                last;
    } out_word_t;

endpackage

>>> rtl/lcns_lane.sv
// One comparator lane: flags a CDF entry that lies below the magnitude.
module lcns_lane
    import lcns_pkg::*;
(
    input  logic [ENTRY_W-1:0] entry,
    input  logic [ENTRY_W-1:0] mag,
    input  logic               narrow,
    input  logic               enable,
    output logic               below
);

    logic [15:0] diff_wide;
    logic [7:0]  diff_narrow;

    // Top bit of (entry - mag) at 16 or 8 bits
    always_comb
    begin
        diff_wide   = {1'b0, entry} - {1'b0, mag};
        diff_narrow = entry[7:0] - {1'b0, mag[6:0]};
        below       = enable & (narrow ? diff_narrow[7] : diff_wide[15]);
    end

endmodule

>>> rtl/lcns_merge.sv
// Merge stage: counts lane hits and applies the sign.
module lcns_merge
    import lcns_pkg::*;
#(
    parameter int NUM_LANES = 5
)
(
    input  logic [NUM_LANES-1:0] below,
    input  logic                 sign,
    output logic [SAMPLE_W-1:0]  sample
);

    localparam int CNT_W = $clog2(NUM_LANES + 1);

    logic [CNT_W-1:0] count;

    // Population count, then conditional negate mod 2^16
    always_comb
    begin
        count = '0;
        for (int j = 0; j < NUM_LANES; j++)
        begin
            count = count + CNT_W'(below[j]);
        end
        sample = sign ? (SAMPLE_W'(0) - SAMPLE_W'(count)) : SAMPLE_W'(count);
    end

endmodule

>>> rtl/lwe_cdf_noise_sampler.sv
// Top level of the LWE inverse-CDF noise sampler.
//
// Usage:
//   Input channel (in_valid / in_stall / in_word) carries one word of random
//   bits per item. Output channel (out_valid / out_stall / out_word) carries
//   signed 16-bit noise samples; out_word.last marks the final sample of an
//   input word. Configuration is written through cfg_write_en / cfg_index /
//   cfg_data while the block is idle.
//   Every sample comes combinationally from a bank of comparator lanes (one
//   per compared CDF entry, two banks for the two 12-bit samples) feeding a
//   count-and-sign merge stage; the result lands in the output register.
//   out_valid rises in the cycle after a word is accepted.
//   Throughput: one word per cycle, unless the receiver stalls, in 8- and
//   16-bit modes and in 12-bit mode with odd_tail set; otherwise a 12-bit word
//   holds off the next until its second sample leaves the single output port.
//   Reset clears the output buffer and loads the default configuration:
//   16-bit mode, table length 6, all CDF entries zero.
//   When the receiver stalls, the held samples stay put and in_stall rises
//   once the output buffer cannot take another word.
module lwe_cdf_noise_sampler
    import lcns_pkg::*;
#(
    parameter int CDF_ENTRIES = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [2:0]         cfg_index,
    input  logic [ENTRY_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_word_t           in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output out_word_t          out_word
);

    localparam int NUM_LANES = CDF_ENTRIES - 1;

    // Configuration registers
    logic [1:0]         mode_reg;
    logic [2:0]         table_len_reg;
    logic [ENTRY_W-1:0] cdf_entry_reg [ENTRY_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_16BIT;
            table_len_reg <= 3'd6;
            for (int j = 0; j < ENTRY_REGS; j++)
            begin
                cdf_entry_reg[j] <= '0;
            end
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == REG_MODE)
            begin
                mode_reg <= cfg_data[1:0];
            end
            else if (cfg_index == REG_TABLE_LEN)
            begin
                table_len_reg <= cfg_data[2:0];
            end
            else if (cfg_index >= REG_ENTRY_0 &&
                     cfg_index < REG_ENTRY_0 + 3'(ENTRY_REGS))
            begin
                cdf_entry_reg[cfg_index - REG_ENTRY_0] <= cfg_data;
            end
        end
    end

    // Magnitude and sign extraction per mode
    logic [ENTRY_W-1:0] mag  [2];
    logic               sign [2];
    logic               narrow;
    logic               two_samples;

    always_comb
    begin
        mag[1]      = ENTRY_W'(in_word.random_word[12:2]);
        sign[1]     = in_word.random_word[0];
        narrow      = 1'b0;
        two_samples = 1'b0;
        unique case (mode_reg)
            MODE_8BIT:
            begin
                mag[0]  = ENTRY_W'(in_word.random_word[7:1]);
                sign[0] = in_word.random_word[0];
                narrow  = 1'b1;
            end
            MODE_12BIT:
            begin
                mag[0]      = ENTRY_W'(in_word.random_word[23:13]);
                sign[0]     = in_word.random_word[1];
                two_samples = ~in_word.odd_tail;
            end
            default:
            begin
                mag[0]  = in_word.random_word[15:1];
                sign[0] = in_word.random_word[0];
            end
        endcase
    end

    // Comparator lane banks and merge stages
    logic [SAMPLE_W-1:0] sample [2];

    for (genvar g = 0; g < 2; g++)
    begin : g_bank
        logic [NUM_LANES-1:0] below;

        for (genvar j = 0; j < NUM_LANES; j++)
        begin : g_lane
            lcns_lane u_lane (
                .entry  (cdf_entry_reg[j]),
                .mag    (mag[g]),
                .narrow (narrow),
                .enable (table_len_reg > 3'(j + 1)),
                .below  (below[j])
            );
        end

        lcns_merge #(
            .NUM_LANES (NUM_LANES)
        ) u_merge (
            .below  (below),
            .sign   (sign[g]),
            .sample (sample[g])
        );
    end

    // Output buffer: head word shown, tail word queued behind it
    out_word_t  head_reg, head_next;
    out_word_t  tail_reg, tail_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       in_fire;
    logic       out_fire;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_word  = head_reg;
    assign out_fire  = out_valid & ~out_stall;
    assign in_stall  = ~((cnt_reg == 2'd0) || (cnt_reg == 2'd1 && ~out_stall));
    assign in_fire   = in_valid & ~in_stall;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        priority if (in_fire)
        begin
            head_next.noise_sample = sample[0];
            head_next.last         = ~two_samples;
            tail_next.noise_sample = sample[1];
            tail_next.last         = 1'b1;
            cnt_next               = two_samples ? 2'd2 : 2'd1;
        end
        else if (out_fire)
        begin
            head_next = tail_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

>>> rtl/lcns_checker.sv
// Port-level checker for the noise sampler, bound to the top level.
module lcns_checker
    import lcns_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_word
);

    // A stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

    // An empty block takes input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
    else $error("input stalled while block is empty");

    // The second sample of a word follows right after the first
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.last && !out_stall |=> out_valid && out_word.last)
    else $error("second sample missing after first");

    // Final sample leaving frees room for the next word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.last && !out_stall |-> !in_stall)
    else $error("input stalled while last sample drains");

    // An accepted word shows up in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
    else $error("accepted word produced no output");

endmodule

bind lwe_cdf_noise_sampler lcns_checker u_lcns_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

>>> tb/sv/tb_lwe_cdf_noise_sampler.sv
// Testbench for the LWE inverse-CDF noise sampler: directed table, random words, local predictor.
`timescale 1ns / 100ps

module tb_lwe_cdf_noise_sampler;
    import lcns_pkg::*;

    localparam int CDF_ENTRIES    = 6;
    localparam int RAND_PHASES    = 16;
    localparam int WORDS_PER_PHASE = 100;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;

    // Index with no register behind it, and the mode code that falls back to 16-bit
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam logic [1:0] MODE_ALT   = 2'd3;

    // One row of the directed table: a register write or an input word
    typedef struct packed {
        logic                is_cfg;
        logic [2:0]          idx;
        logic [ENTRY_W-1:0]  data;
        in_word_t            item;
        logic                fixed;
        logic [SAMPLE_W-1:0] sample;
    } plan_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write_en;
    logic [2:0]         cfg_index;
    logic [ENTRY_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_stall;
    in_word_t           in_word;
    logic               out_valid;
    logic               out_stall;
    out_word_t          out_word;

    // Shadow copy of the configuration registers
    logic [1:0]         mode_sh;
    logic [2:0]         table_len_sh;
    logic [ENTRY_W-1:0] cdf_sh [ENTRY_REGS];

    plan_row_t plan_q[$];
    out_word_t expected_samples[$];
    int        mismatches;
    int        idle_cycles;
    bit        idle_on;
    bit        cfg_open;

    lwe_cdf_noise_sampler #(.CDF_ENTRIES(CDF_ENTRIES)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_word      (in_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_word     (out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Count the compared entries below mag, then apply the sign
    function automatic logic [SAMPLE_W-1:0] sample_for(logic [ENTRY_W-1:0] mag, logic sgn,
                                                       logic narrow);
        int                  lanes;
        logic [7:0]          gap8;
        logic [15:0]         gap16;
        logic [SAMPLE_W-1:0] cnt;
        lanes = (table_len_sh == 3'd0) ? 0 : int'(table_len_sh) - 1;
        if (lanes > CDF_ENTRIES - 1)
            lanes = CDF_ENTRIES - 1;
        if (lanes > ENTRY_REGS)
            lanes = ENTRY_REGS;
        cnt = '0;
        for (int j = 0; j < lanes; j++)
        begin
            if (narrow)
            begin
                gap8 = cdf_sh[j][7:0] - mag[7:0];
                cnt  = cnt + SAMPLE_W'(gap8[7]);
            end
            else
            begin
                gap16 = {1'b0, cdf_sh[j]} - {1'b0, mag};
                cnt   = cnt + SAMPLE_W'(gap16[15]);
            end
        end
        return sgn ? (16'd0 - cnt) : cnt;
    endfunction

    // Expected samples of one input word under the current settings
    function automatic void predict_samples(in_word_t w);
        logic [RAND_W-1:0] r;
        r = w.random_word;
        case (mode_sh)
            MODE_8BIT:
                expected_samples.push_back(out_word_t'({sample_for({8'd0, r[7:1]}, r[0], 1'b1),
                                                        1'b1}));
            MODE_12BIT:
            begin
                expected_samples.push_back(out_word_t'({sample_for({4'd0, r[23:13]}, r[1], 1'b0),
                                                        w.odd_tail}));
                if (!w.odd_tail)
                    expected_samples.push_back(
                        out_word_t'({sample_for({4'd0, r[12:2]}, r[0], 1'b0), 1'b1}));
            end
            default:
                expected_samples.push_back(out_word_t'({sample_for(r[15:1], r[0], 1'b0), 1'b1}));
        endcase
    endfunction

    // Directed table builders
    function automatic void add_cfg(logic [2:0] idx, logic [ENTRY_W-1:0] data);
        plan_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        plan_q.push_back(row);
    endfunction

    function automatic void add_item(logic [RAND_W-1:0] w, logic odd);
        plan_row_t row;
        row                  = '0;
        row.item.random_word = w;
        row.item.odd_tail    = odd;
        plan_q.push_back(row);
    endfunction

    function automatic void add_fixed(logic [RAND_W-1:0] w, logic [SAMPLE_W-1:0] sample);
        plan_row_t row;
        row                  = '0;
        row.item.random_word = w;
        row.fixed            = 1'b1;
        row.sample           = sample;
        plan_q.push_back(row);
    endfunction

    // Register write; the first of a run waits until the block has drained
    task automatic write_reg(logic [2:0] idx, logic [ENTRY_W-1:0] data);
        if (!cfg_open)
        begin
            in_valid <= 1'b0;
            while (expected_samples.size() != 0)
                @(posedge clk);
        end
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        cfg_open = 1'b1;
        if (idx == REG_MODE)
            mode_sh = data[1:0];
        else if (idx == REG_TABLE_LEN)
            table_len_sh = data[2:0];
        else if (idx >= REG_ENTRY_0 && idx < REG_ENTRY_0 + 3'(ENTRY_REGS))
            cdf_sh[idx - REG_ENTRY_0] = data;
    endtask

    // Send one word; returns at the edge where it is taken, valid left high
    task automatic send_item(in_word_t w, logic fixed, logic [SAMPLE_W-1:0] sample);
        bit taken;
        if (cfg_open)
        begin
            cfg_write_en <= 1'b0;
            cfg_open = 1'b0;
        end
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        if (fixed)
            expected_samples.push_back(out_word_t'({sample, 1'b1}));
        else
            predict_samples(w);
        in_valid <= 1'b1;
        in_word  <= w;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Random table per phase, with ranges that suit the chosen mode
    task automatic program_table();
        logic [1:0]         m;
        logic [2:0]         tl;
        logic [ENTRY_W-1:0] span;
        m  = 2'($urandom_range(0, 3));
        tl = 3'($urandom_range(0, 7));
        write_reg(REG_MODE, ($urandom_range(0, 3) == 0) ? {13'($urandom()), m} : {13'd0, m});
        write_reg(REG_TABLE_LEN,
                  ($urandom_range(0, 3) == 0) ? {12'($urandom()), tl} : {12'd0, tl});
        span = (m == MODE_12BIT) ? 15'h07FF : 15'h7FFF;
        if ($urandom_range(0, 3) == 0)
            span = 15'h7FFF;
        for (int j = 0; j < ENTRY_REGS; j++)
            write_reg(REG_ENTRY_0 + 3'(j), 15'($urandom()) & span);
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, 15'($urandom()));
    endtask

    // Receiver back-pressure in bursts
    initial
    begin : backpressure
        int hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                if (hold == 0)
                    out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(1, 8);
                out_stall <= 1'b1;
            end
        end
    end

    // Output checker: a word seen valid and unstalled here is taken at the next edge
    always @(negedge clk)
    begin : sample_check
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
                report_mismatch($sformatf("unexpected sample %h last %b",
                                          out_word.noise_sample, out_word.last));
            else
            begin
                want = expected_samples.pop_front();
                if (out_word.noise_sample !== want.noise_sample)
                    report_mismatch($sformatf("noise_sample got %h want %h",
                                              out_word.noise_sample, want.noise_sample));
                if (out_word.last !== want.last)
                    report_mismatch($sformatf("last got %b want %b (sample %h)",
                                              out_word.last, want.last, want.noise_sample));
            end
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(negedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        in_word_t w;
        mismatches   = 0;
        idle_cycles  = 0;
        idle_on      = 1'b1;
        cfg_open     = 1'b0;
        mode_sh      = MODE_16BIT;
        table_len_sh = 3'd6;
        for (int j = 0; j < ENTRY_REGS; j++)
            cdf_sh[j] = '0;
        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        in_word      <= '0;

        // Reset defaults: 16-bit mode, five zero entries compared
        add_fixed(24'h000000, 16'h0000);
        add_fixed(24'h000002, 16'h0005);
        add_fixed(24'h000003, 16'hFFFB);
        add_fixed(24'hFFFFFF, 16'hFFFB);
        add_fixed(24'h000001, 16'h0000);    // negative zero

        // 8-bit mode, junk in upper mode bits, entries truncated to a byte
        add_cfg(REG_MODE, {13'h1FFF, MODE_8BIT});
        add_cfg(REG_TABLE_LEN, 15'd6);
        add_cfg(REG_ENTRY_0, 15'h0000);
        add_cfg(REG_ENTRY_0 + 3'd1, 15'h0105);
        add_cfg(REG_ENTRY_0 + 3'd2, 15'h7F40);
        add_cfg(REG_ENTRY_0 + 3'd3, 15'h0080);
        add_cfg(REG_ENTRY_0 + 3'd4, 15'h7FFF);
        add_cfg(REG_UNUSED, 15'h7FFF);      // ignored
        add_item(24'h000000, 1'b0);
        add_item(24'hFFFF00, 1'b1);
        add_item(24'h0000FF, 1'b0);
        add_item(24'h000001, 1'b0);
        add_item(24'h00000A, 1'b0);
        add_item(24'h000081, 1'b0);

        // 12-bit mode, oversized table length saturates
        add_cfg(REG_MODE, {13'd0, MODE_12BIT});
        add_cfg(REG_TABLE_LEN, 15'h7FFF);
        add_cfg(REG_ENTRY_0, 15'h0000);
        add_cfg(REG_ENTRY_0 + 3'd1, 15'h0001);
        add_cfg(REG_ENTRY_0 + 3'd2, 15'h03FF);
        add_cfg(REG_ENTRY_0 + 3'd3, 15'h07FF);
        add_cfg(REG_ENTRY_0 + 3'd4, 15'h7FFF);
        add_item(24'hFFFFFF, 1'b0);
        add_item(24'hFFFFFF, 1'b1);
        add_item(24'h000000, 1'b0);
        add_item(24'h000003, 1'b0);
        add_item(24'hAAAAAA, 1'b0);
        add_item(24'h555555, 1'b1);
        add_item(24'h002004, 1'b0);

        // Mode 3 acts as 16-bit; table length 0 and 1 compare nothing
        add_cfg(REG_MODE, {13'd0, MODE_ALT});
        add_cfg(REG_TABLE_LEN, 15'd0);
        add_fixed(24'hFFFFFF, 16'h0000);
        add_fixed(24'h123457, 16'h0000);
        add_cfg(REG_TABLE_LEN, 15'd1);
        add_fixed(24'h00FFFF, 16'h0000);
        add_cfg(REG_TABLE_LEN, 15'd2);
        add_cfg(REG_ENTRY_0, 15'h7FFF);
        add_item(24'h00FFFF, 1'b0);
        add_item(24'h000002, 1'b0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (plan_q[i])
        begin
            if (plan_q[i].is_cfg)
                write_reg(plan_q[i].idx, plan_q[i].data);
            else
                send_item(plan_q[i].item, plan_q[i].fixed, plan_q[i].sample);
        end

        // Random phases; the last one runs without idling
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            idle_on = (ph == RAND_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            program_table();
            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                w.random_word = 24'($urandom());
                w.odd_tail    = 1'($urandom_range(0, 1));
                send_item(w, 1'b0, '0);
            end
        end

        // Drain
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
